// ===== rtl/aqi_pkg.sv =====
`timescale 1ns / 1ps

package aqi_pkg;

  // Table geometry and default row count
  localparam int unsigned TAB_ROWS     = 6;
  localparam int unsigned SEGMENTS_DEF = 6;
  localparam int unsigned LANES        = 5;

  // Field widths
  localparam int unsigned LEVEL_W = 14;
  localparam int unsigned VOC_W   = 9;
  localparam int unsigned SUB_W   = 10;
  localparam int unsigned CAT_W   = 3;
  localparam int unsigned IN_W    = 72;
  localparam int unsigned OUT_W   = 64;

  // Datapath widths
  localparam int unsigned DI_W    = 8;   // index span of one segment
  localparam int unsigned DEN2_W  = 14;  // twice the level span of one segment
  localparam int unsigned RECIP_W = 17;  // floor(2^RECIP_SH / den2)
  localparam int unsigned NUM_W   = 24;  // rounded numerator, non-negative part
  localparam int unsigned OFF_W   = 16;  // level minus segment low bound
  localparam int unsigned PROD_W  = 25;  // span times offset
  localparam int unsigned RECIP_SH = 24;
  localparam int unsigned QUO_W   = NUM_W + RECIP_W - RECIP_SH;

  localparam logic [SUB_W-1:0] SUB_MAX = 10'd1023;

  // Pipeline depth
  localparam int unsigned LANE_STAGES  = 6;
  localparam int unsigned MERGE_STAGES = 2;
  localparam int unsigned PIPE_STAGES  = LANE_STAGES + MERGE_STAGES;

  // Category codes
  localparam logic [CAT_W-1:0] CAT_GOOD      = 3'd0;
  localparam logic [CAT_W-1:0] CAT_MODERATE  = 3'd1;
  localparam logic [CAT_W-1:0] CAT_SENSITIVE = 3'd2;
  localparam logic [CAT_W-1:0] CAT_UNHEALTHY = 3'd3;
  localparam logic [CAT_W-1:0] CAT_VERY_BAD  = 3'd4;
  localparam logic [CAT_W-1:0] CAT_HAZARDOUS = 3'd5;

  typedef enum logic [2:0] {
    LANE_PM1  = 3'd0,
    LANE_PM25 = 3'd1,
    LANE_PM4  = 3'd2,
    LANE_PM10 = 3'd3,
    LANE_VOC  = 3'd4
  } lane_e;

  // Breakpoints per pollutant: c_lo, c_hi, i_lo, i_hi
  localparam int unsigned BP_TAB [LANES][TAB_ROWS][4] = '{
    '{ '{0, 80, 0, 50}, '{81, 254, 51, 100}, '{255, 354, 101, 150},
       '{355, 504, 151, 200}, '{505, 754, 201, 300}, '{755, 5004, 301, 500} },
    '{ '{0, 120, 0, 50}, '{121, 354, 51, 100}, '{355, 554, 101, 150},
       '{555, 1504, 151, 200}, '{1505, 2504, 201, 300}, '{2505, 5004, 301, 500} },
    '{ '{0, 350, 0, 50}, '{351, 754, 51, 100}, '{755, 1254, 101, 150},
       '{1255, 1754, 151, 200}, '{1755, 2504, 201, 300}, '{2505, 5004, 301, 500} },
    '{ '{0, 540, 0, 50}, '{550, 1540, 51, 100}, '{1550, 2540, 101, 150},
       '{2550, 3540, 151, 200}, '{3550, 4240, 201, 300}, '{4250, 6040, 301, 500} },
    '{ '{0, 300, 0, 50}, '{300, 500, 51, 100}, '{500, 1000, 101, 150},
       '{1000, 3000, 151, 200}, '{4000, 5000, 201, 300}, '{5000, 10000, 301, 500} }
  };

  // floor(2^24 / (2 * (c_hi - c_lo))) for each row above
  localparam int unsigned RECIP_TAB [LANES][TAB_ROWS] = '{
    '{104857, 48489, 84733, 56299, 33689, 1974},
    '{69905, 36002, 42153, 8839, 8397, 3356},
    '{23967, 20815, 16810, 16810, 11199, 3356},
    '{15534, 8473, 8473, 8473, 12157, 4686},
    '{27962, 41943, 16777, 4194, 8388, 1677}
  };

  // Per-segment constants as the lane datapath uses them
  typedef struct packed {
    logic [LEVEL_W-1:0] c_lo;
    logic [LEVEL_W-1:0] c_hi;
    logic [DI_W-1:0]    d_i;
    logic [DEN2_W-1:0]  den2;
    logic [RECIP_W-1:0] recip;
    logic [NUM_W-1:0]   base;   // i_lo * den2 + den, the rounding offset folded in
  } seg_t;

  function automatic seg_t seg_row(lane_e lane, int unsigned row);
    seg_t        s;
    int unsigned l;
    int unsigned clo;
    int unsigned chi;
    int unsigned ilo;
    int unsigned ihi;
    l   = int'(lane);
    clo = BP_TAB[l][row][0];
    chi = BP_TAB[l][row][1];
    ilo = BP_TAB[l][row][2];
    ihi = BP_TAB[l][row][3];
    s.c_lo  = LEVEL_W'(clo);
    s.c_hi  = LEVEL_W'(chi);
    s.d_i   = DI_W'(ihi - ilo);
    s.den2  = DEN2_W'(2 * (chi - clo));
    s.recip = RECIP_W'(RECIP_TAB[l][row]);
    s.base  = NUM_W'(ilo * 2 * (chi - clo) + (chi - clo));
    return s;
  endfunction

  typedef logic [LANES-1:0][SUB_W-1:0] sub_vec_t;

  // Result word fields
  typedef struct packed {
    logic [CAT_W-1:0] category;
    logic [SUB_W-1:0] overall_index;
    sub_vec_t         subs;
  } result_t;

endpackage

// ===== rtl/aqi_lane.sv =====
`timescale 1ns / 1ps

module aqi_lane import aqi_pkg::*; #(
  parameter lane_e       LANE     = LANE_PM1,
  parameter int unsigned SEGMENTS = SEGMENTS_DEF
) (
  input  logic                   clk_i,
  input  logic [LANE_STAGES-1:0] en_i,
  input  logic [LEVEL_W-1:0]     level_i,
  output logic [SUB_W-1:0]       sub_o
);

  localparam int unsigned ROWS  = (SEGMENTS < TAB_ROWS) ? SEGMENTS : TAB_ROWS;
  localparam int unsigned SEL_W = $clog2(ROWS);

  seg_t             row_tab [ROWS];
  logic [SEL_W-1:0] pick;
  seg_t             sel;

  // Build the breakpoint rows of this pollutant
  always_comb begin
    for (int i = 0; i < ROWS; i++) begin
      row_tab[i] = seg_row(LANE, i);
    end
  end

  // Pick the first segment whose upper bound holds the level, else the top one
  always_comb begin
    pick = SEL_W'(ROWS - 1);
    for (int i = ROWS - 1; i >= 0; i--) begin
      if (level_i <= row_tab[i].c_hi) begin
        pick = SEL_W'(i);
      end
    end
  end

  assign sel = row_tab[pick];

  // Stage 1: offset into the segment and its constants
  logic signed [OFF_W-1:0] off_q;
  logic [DI_W-1:0]         di_q;
  logic [NUM_W-1:0]        base1_q;
  logic [DEN2_W-1:0]       den1_q;
  logic [RECIP_W-1:0]      rc1_q;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      off_q   <= $signed({2'b00, level_i}) - $signed({2'b00, sel.c_lo});
      di_q    <= sel.d_i;
      base1_q <= sel.base;
      den1_q  <= sel.den2;
      rc1_q   <= sel.recip;
    end
  end

  // Stage 2: span times offset
  logic signed [PROD_W-1:0] prod_q;
  logic [NUM_W-1:0]         base2_q;
  logic [DEN2_W-1:0]        den2_q;
  logic [RECIP_W-1:0]       rc2_q;

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      prod_q  <= $signed({1'b0, di_q}) * off_q;
      base2_q <= base1_q;
      den2_q  <= den1_q;
      rc2_q   <= rc1_q;
    end
  end

  // Stage 3: rounded numerator, flag a negative one
  logic signed [NUM_W+1:0] num_s;
  logic                    neg3_q;
  logic [NUM_W-1:0]        num3_q;
  logic [DEN2_W-1:0]       den3_q;
  logic [RECIP_W-1:0]      rc3_q;

  assign num_s = $signed({2'b00, base2_q}) + ($signed({prod_q[PROD_W-1], prod_q}) <<< 1);

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      neg3_q <= num_s[NUM_W+1];
      num3_q <= num_s[NUM_W-1:0];
      den3_q <= den2_q;
      rc3_q  <= rc2_q;
    end
  end

  // Stage 4: quotient estimate from the reciprocal, at most one short
  logic [NUM_W+RECIP_W-1:0] est;
  logic [QUO_W-1:0]         q4_q;
  logic [NUM_W-1:0]         num4_q;
  logic [DEN2_W-1:0]        den4_q;
  logic                     neg4_q;

  assign est = num3_q * rc3_q;

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      q4_q   <= est[NUM_W+RECIP_W-1:RECIP_SH];
      num4_q <= num3_q;
      den4_q <= den3_q;
      neg4_q <= neg3_q;
    end
  end

  // Stage 5: remainder of the estimate
  logic [QUO_W+DEN2_W-1:0] back;
  logic [NUM_W-1:0]        rem5_q;
  logic [QUO_W-1:0]        q5_q;
  logic [DEN2_W-1:0]       den5_q;
  logic                    neg5_q;

  assign back = q4_q * den4_q;

  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      rem5_q <= num4_q - back[NUM_W-1:0];
      q5_q   <= q4_q;
      den5_q <= den4_q;
      neg5_q <= neg4_q;
    end
  end

  // Stage 6: correct by one, clamp at zero and saturate
  logic [QUO_W:0]     q_fix;
  logic [SUB_W-1:0]   sub_q;

  assign q_fix = {1'b0, q5_q} + ((rem5_q >= NUM_W'(den5_q)) ? (QUO_W+1)'(1) : '0);

  always_ff @(posedge clk_i) begin
    if (en_i[5]) begin
      if (neg5_q) begin
        sub_q <= '0;
      end else if (q_fix > (QUO_W+1)'(SUB_MAX)) begin
        sub_q <= SUB_MAX;
      end else begin
        sub_q <= q_fix[SUB_W-1:0];
      end
    end
  end

  assign sub_o = sub_q;

endmodule

// ===== rtl/aqi_merge.sv =====
`timescale 1ns / 1ps

module aqi_merge import aqi_pkg::*; (
  input  logic                    clk_i,
  input  logic [MERGE_STAGES-1:0] en_i,
  input  logic                    combine_all_five_i,
  input  sub_vec_t                subs_i,
  output result_t                 result_o
);

  logic [SUB_W-1:0] max_core;
  logic [SUB_W-1:0] max_all;
  logic [SUB_W-1:0] max_q;
  sub_vec_t         subs_q;
  logic [CAT_W-1:0] cat;
  result_t          result_q;

  // Maximum over PM2.5, PM10 and VOC, widened to all five on request
  always_comb begin
    max_core = subs_i[LANE_PM25];
    if (subs_i[LANE_PM10] > max_core) begin
      max_core = subs_i[LANE_PM10];
    end
    if (subs_i[LANE_VOC] > max_core) begin
      max_core = subs_i[LANE_VOC];
    end
    max_all = max_core;
    if (combine_all_five_i) begin
      if (subs_i[LANE_PM1] > max_all) begin
        max_all = subs_i[LANE_PM1];
      end
      if (subs_i[LANE_PM4] > max_all) begin
        max_all = subs_i[LANE_PM4];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      max_q  <= max_all;
      subs_q <= subs_i;
    end
  end

  // Category bands of the overall index
  always_comb begin
    if (max_q <= SUB_W'(50)) begin
      cat = CAT_GOOD;
    end else if (max_q <= SUB_W'(100)) begin
      cat = CAT_MODERATE;
    end else if (max_q <= SUB_W'(150)) begin
      cat = CAT_SENSITIVE;
    end else if (max_q <= SUB_W'(200)) begin
      cat = CAT_UNHEALTHY;
    end else if (max_q <= SUB_W'(300)) begin
      cat = CAT_VERY_BAD;
    end else begin
      cat = CAT_HAZARDOUS;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      result_q.category      <= cat;
      result_q.overall_index <= max_q;
      result_q.subs          <= subs_q;
    end
  end

  assign result_o = result_q;

endmodule

// ===== rtl/air_quality_index_calc_top.sv =====
`timescale 1ns / 1ps

// Channel   Dir  Width  Word
// s_axis    in   72     one reading of five pollutant levels
// m_axis    out  64     five sub-indices, overall index, category
// cfg       in   1      combine_all_five mode bit
//
// Eight pipeline stages: six in each of the five pollutant lanes (segment pick,
// span multiply, numerator, reciprocal multiply, remainder, correction) and two
// in the merge (maximum, category). One reading per cycle while the output is not stalled.
// Each stage holds its word while the next one is full and stalled, so bubbles
// close up under output backpressure. Reset clears stage valids and sets the mode to 1.

module air_quality_index_calc_top import aqi_pkg::*; #(
  parameter int unsigned SEGMENTS = SEGMENTS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // pm1_level[13:0], pm25_level[27:14], pm4_level[41:28], pm10_level[55:42],
  // voc_level[64:56], zero fill [71:65]
  input  logic [IN_W-1:0]  s_axis_tdata,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // pm1_sub[9:0], pm25_sub[19:10], pm4_sub[29:20], pm10_sub[39:30],
  // voc_sub[49:40], overall_index[59:50], category[62:60], zero fill [63]
  output logic [OUT_W-1:0] m_axis_tdata,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic             cfg_data_i
);

  logic                   combine_all_five_q;
  logic [PIPE_STAGES-1:0] vld_q;
  logic [PIPE_STAGES-1:0] adv;
  logic [LEVEL_W-1:0]     level [LANES];
  sub_vec_t               subs;
  result_t                result;

  // Mode register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      combine_all_five_q <= 1'b1;
    end else if (cfg_valid_i) begin
      combine_all_five_q <= cfg_data_i;
    end
  end

  // Advance a stage when it is empty or its successor advances
  always_comb begin
    adv[PIPE_STAGES-1] = !vld_q[PIPE_STAGES-1] || m_axis_tready;
    for (int k = PIPE_STAGES - 2; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) begin
        vld_q[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < PIPE_STAGES; k++) begin
        if (adv[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  assign s_axis_tready = adv[0];
  assign m_axis_tvalid = vld_q[PIPE_STAGES-1];

  // Unpack the input word
  assign level[LANE_PM1]  = s_axis_tdata[13:0];
  assign level[LANE_PM25] = s_axis_tdata[27:14];
  assign level[LANE_PM4]  = s_axis_tdata[41:28];
  assign level[LANE_PM10] = s_axis_tdata[55:42];
  assign level[LANE_VOC]  = {{(LEVEL_W-VOC_W){1'b0}}, s_axis_tdata[64:56]};

  // One lane per pollutant
  for (genvar g = 0; g < LANES; g++) begin : g_lane
    aqi_lane #(
      .LANE     (lane_e'(g)),
      .SEGMENTS (SEGMENTS)
    ) u_lane (
      .clk_i   (clk_i),
      .en_i    (adv[LANE_STAGES-1:0]),
      .level_i (level[g]),
      .sub_o   (subs[g])
    );
  end

  aqi_merge u_merge (
    .clk_i              (clk_i),
    .en_i               (adv[PIPE_STAGES-1:LANE_STAGES]),
    .combine_all_five_i (combine_all_five_q),
    .subs_i             (subs),
    .result_o           (result)
  );

  // Pack the result word
  assign m_axis_tdata = {1'b0, result.category, result.overall_index,
                         result.subs[LANE_VOC], result.subs[LANE_PM10],
                         result.subs[LANE_PM4], result.subs[LANE_PM25],
                         result.subs[LANE_PM1]};

endmodule
